@@ hw/rtl/thr_pkg.sv @@
`default_nettype none

package thr_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned HYST_W  = 9;
  localparam int unsigned THR_W   = 12;
  localparam int unsigned LOCK_W  = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_PLATE_SETPOINT       = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLATE_HYSTERESIS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CONTAINER_SETPOINT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CONTAINER_HYSTERESIS = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIX_THRESHOLD        = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOCKOUT_MS           = 3'd5;

  localparam logic signed [TEMP_W-1:0] PLATE_SETPOINT_RST       = 12'sd48;
  localparam logic [HYST_W-1:0]        PLATE_HYSTERESIS_RST     = 9'd16;
  localparam logic signed [TEMP_W-1:0] CONTAINER_SETPOINT_RST   = 12'sd96;
  localparam logic [HYST_W-1:0]        CONTAINER_HYSTERESIS_RST = 9'd0;
  localparam logic [THR_W-1:0]         MIX_THRESHOLD_RST        = 12'd16;
  localparam logic [LOCK_W-1:0]        LOCKOUT_MS_RST           = 16'd5000;

  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_LOWER = 2'd1;
  localparam logic [1:0] MOVE_LIFT  = 2'd2;

  localparam logic [1:0] IND_UNSET   = 2'd0;
  localparam logic [1:0] IND_OVER    = 2'd1;
  localparam logic [1:0] IND_NOMINAL = 2'd2;
  localparam logic [1:0] IND_UNDER   = 2'd3;

  typedef struct packed {
    logic [STAMP_W-1:0]        now_ms;
    logic signed [TEMP_W-1:0]  plate_temp;
    logic signed [TEMP_W-1:0]  left_temp;
    logic signed [TEMP_W-1:0]  right_temp;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  plate_setpoint;
    logic [HYST_W-1:0]         plate_hysteresis;
    logic signed [TEMP_W-1:0]  container_setpoint;
    logic [HYST_W-1:0]         container_hysteresis;
    logic [THR_W-1:0]          mix_threshold;
    logic [LOCK_W-1:0]         lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic                tray_down;
    logic [STAMP_W-1:0]  tray_last_ms;
    logic [STAMP_W-1:0]  indicator_last_ms;
    logic [STAMP_W-1:0]  coolant_last_ms;
    logic [STAMP_W-1:0]  mixing_last_ms;
    logic [1:0]          indicator_mode;
    logic                coolant_level;
    logic                mixing_level;
  } state_t;

  typedef struct packed {
    logic [1:0]                tray_move;
    logic                      tray_is_down;
    logic [1:0]                indicator;
    logic                      coolant_on;
    logic                      mixing_on;
    logic signed [TEMP_W-1:0]  container_average;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/thr_step.sv @@
`default_nettype none

module thr_step (
  input  thr_pkg::sample_t sample,
  input  thr_pkg::cfg_t    cfg,
  input  thr_pkg::state_t  state,
  output thr_pkg::state_t  state_nxt,
  output thr_pkg::result_t result
);
  import thr_pkg::*;

  localparam logic signed [14:0] IND_BAND = 15'sd32;

  function automatic logic lock_over(input logic [STAMP_W-1:0] now,
                                     input logic [STAMP_W-1:0] last,
                                     input logic [LOCK_W-1:0]  lock);
    logic [STAMP_W-1:0] gap;
    gap = now - last;
    return gap > STAMP_W'(lock);
  endfunction

  logic signed [14:0] plate_w;
  logic signed [14:0] left_w;
  logic signed [14:0] right_w;
  logic signed [14:0] sum_w;
  logic signed [14:0] s2_w;
  logic signed [14:0] ch2_w;
  logic signed [14:0] psp_w;
  logic signed [14:0] ph_w;
  logic signed [14:0] dev_w;
  logic signed [14:0] dlr_w;
  logic signed [14:0] thr_w;

  logic tray_ok, ind_ok, cool_ok, mix_ok;
  logic do_lower, do_lift;
  logic do_over, do_nominal, do_under;
  logic do_cool_on, do_cool_off;
  logic mix_want;

  always_comb begin
    plate_w = 15'(sample.plate_temp);
    left_w  = 15'(sample.left_temp);
    right_w = 15'(sample.right_temp);
    sum_w   = left_w + right_w;
    s2_w    = 15'(cfg.container_setpoint) + 15'(cfg.container_setpoint);
    ch2_w   = 15'({cfg.container_hysteresis, 1'b0});
    psp_w   = 15'(cfg.plate_setpoint);
    ph_w    = 15'(cfg.plate_hysteresis);
    dev_w   = sum_w - s2_w;
    dlr_w   = left_w - right_w;
    thr_w   = 15'(cfg.mix_threshold);

    tray_ok = lock_over(sample.now_ms, state.tray_last_ms, cfg.lockout_ms);
    ind_ok  = lock_over(sample.now_ms, state.indicator_last_ms, cfg.lockout_ms);
    cool_ok = lock_over(sample.now_ms, state.coolant_last_ms, cfg.lockout_ms);
    mix_ok  = lock_over(sample.now_ms, state.mixing_last_ms, cfg.lockout_ms);

    // Each actuator's conditions are mutually exclusive, so at most one fires.
    do_lower    = (plate_w > psp_w + ph_w) && !state.tray_down && tray_ok;
    do_lift     = (plate_w <= psp_w - ph_w) && state.tray_down && tray_ok;
    do_over     = (sum_w >= s2_w + IND_BAND) && ind_ok;
    do_nominal  = (dev_w < IND_BAND) && (dev_w > -IND_BAND) && ind_ok;
    do_under    = (sum_w <= s2_w - IND_BAND) && ind_ok;
    do_cool_on  = (sum_w > s2_w + ch2_w) && cool_ok;
    do_cool_off = (sum_w <= s2_w - ch2_w) && cool_ok;
    mix_want    = (dlr_w > thr_w) || (dlr_w < -thr_w);

    state_nxt = state;
    if (do_lower || do_lift) begin
      state_nxt.tray_down    = do_lower;
      state_nxt.tray_last_ms = sample.now_ms;
    end
    if (do_over || do_nominal || do_under) begin
      state_nxt.indicator_last_ms = sample.now_ms;
      if (do_over) begin
        state_nxt.indicator_mode = IND_OVER;
      end else if (do_nominal) begin
        state_nxt.indicator_mode = IND_NOMINAL;
      end else begin
        state_nxt.indicator_mode = IND_UNDER;
      end
    end
    if (do_cool_on || do_cool_off) begin
      state_nxt.coolant_level   = do_cool_on;
      state_nxt.coolant_last_ms = sample.now_ms;
    end
    if (mix_ok) begin
      state_nxt.mixing_level   = mix_want;
      state_nxt.mixing_last_ms = sample.now_ms;
    end

    if (do_lower) begin
      result.tray_move = MOVE_LOWER;
    end else if (do_lift) begin
      result.tray_move = MOVE_LIFT;
    end else begin
      result.tray_move = MOVE_NONE;
    end
    result.tray_is_down      = state_nxt.tray_down;
    result.indicator         = state_nxt.indicator_mode;
    result.coolant_on        = state_nxt.coolant_level;
    result.mixing_on         = state_nxt.mixing_level;
    result.container_average = sum_w[12:1];
  end

endmodule

`default_nettype wire

@@ hw/rtl/thermal_hysteresis_regulator.sv @@
`default_nettype none

// Channel  Direction  Handshake         Payload
// in_      request    in_valid/in_stall now_ms, plate_temp, left_temp, right_temp
// out_     result     out_valid/out_stall tray_move .. container_average
// cfg_     write      cfg_we            cfg_index, cfg_wdata
//
// One request is accepted per clock unless out_stall backs up both registers; decision logic
// between the input and result registers is combinational and sets the rate.
// Reset is synchronous, active low, and restores valid bits, settings and actuator state.
// A stalled result holds in the result register while the input register can still fill;
// in_stall rises only when both registers are occupied and out_stall is high.

module thermal_hysteresis_regulator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [thr_pkg::STAMP_W-1:0]          in_now_ms,
  input  wire signed [thr_pkg::TEMP_W-1:0]    in_plate_temp,
  input  wire signed [thr_pkg::TEMP_W-1:0]    in_left_temp,
  input  wire signed [thr_pkg::TEMP_W-1:0]    in_right_temp,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_tray_move,
  output logic                                out_tray_is_down,
  output logic [1:0]                          out_indicator,
  output logic                                out_coolant_on,
  output logic                                out_mixing_on,
  output logic signed [thr_pkg::TEMP_W-1:0]   out_container_average,
  input  wire                                 cfg_we,
  input  wire [thr_pkg::IDX_W-1:0]            cfg_index,
  input  wire [thr_pkg::CFG_W-1:0]            cfg_wdata
);
  import thr_pkg::*;

  logic    s1_valid_r;
  sample_t s1_data_r;
  logic    s2_valid_r;
  result_t s2_data_r;
  state_t  state_r;
  state_t  state_nxt;
  cfg_t    cfg_r;
  result_t step_res;

  logic s2_ready;
  logic s1_fire;
  logic in_fire;

  assign s2_ready = !s2_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_fire  = in_valid && !in_stall;

  thr_step u_step (
    .sample    (s1_data_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        s2_valid_r <= 1'b1;
        state_r    <= state_nxt;
      end else if (!out_stall) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r.now_ms     <= in_now_ms;
      s1_data_r.plate_temp <= in_plate_temp;
      s1_data_r.left_temp  <= in_left_temp;
      s1_data_r.right_temp <= in_right_temp;
    end
    if (s1_fire) begin
      s2_data_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plate_setpoint       <= PLATE_SETPOINT_RST;
      cfg_r.plate_hysteresis     <= PLATE_HYSTERESIS_RST;
      cfg_r.container_setpoint   <= CONTAINER_SETPOINT_RST;
      cfg_r.container_hysteresis <= CONTAINER_HYSTERESIS_RST;
      cfg_r.mix_threshold        <= MIX_THRESHOLD_RST;
      cfg_r.lockout_ms           <= LOCKOUT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLATE_SETPOINT:       cfg_r.plate_setpoint       <= cfg_wdata[TEMP_W-1:0];
        REG_PLATE_HYSTERESIS:     cfg_r.plate_hysteresis     <= cfg_wdata[HYST_W-1:0];
        REG_CONTAINER_SETPOINT:   cfg_r.container_setpoint   <= cfg_wdata[TEMP_W-1:0];
        REG_CONTAINER_HYSTERESIS: cfg_r.container_hysteresis <= cfg_wdata[HYST_W-1:0];
        REG_MIX_THRESHOLD:        cfg_r.mix_threshold        <= cfg_wdata[THR_W-1:0];
        REG_LOCKOUT_MS:           cfg_r.lockout_ms           <= cfg_wdata[LOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid             = s2_valid_r;
  assign out_tray_move         = s2_data_r.tray_move;
  assign out_tray_is_down      = s2_data_r.tray_is_down;
  assign out_indicator         = s2_data_r.indicator;
  assign out_coolant_on        = s2_data_r.coolant_on;
  assign out_mixing_on         = s2_data_r.mixing_on;
  assign out_container_average = s2_data_r.container_average;

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(state_r))
    else $error("actuator state changed without a request");

  a_tray_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && step_res.tray_move == MOVE_NONE |=> $stable(state_r.tray_down))
    else $error("tray position changed without a move");

  a_lower_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tray_move == MOVE_LOWER |-> out_tray_is_down)
    else $error("tray lowered but reported raised");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r)
    else $error("pending request dropped while stalled");

endmodule

`default_nettype wire

@@ tb/sv/thermal_hysteresis_regulator_checker.sv @@
`timescale 1ns / 1ps

module thermal_hysteresis_regulator_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire [thr_pkg::STAMP_W-1:0]         in_now_ms,
  input  wire signed [thr_pkg::TEMP_W-1:0]   in_plate_temp,
  input  wire signed [thr_pkg::TEMP_W-1:0]   in_left_temp,
  input  wire signed [thr_pkg::TEMP_W-1:0]   in_right_temp,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire [1:0]                          out_tray_move,
  input  wire                                out_tray_is_down,
  input  wire [1:0]                          out_indicator,
  input  wire                                out_coolant_on,
  input  wire                                out_mixing_on,
  input  wire signed [thr_pkg::TEMP_W-1:0]   out_container_average,
  input  wire                                cfg_we,
  input  wire [thr_pkg::IDX_W-1:0]           cfg_index,
  input  wire [thr_pkg::CFG_W-1:0]           cfg_wdata,
  output int                                 mismatch_count,
  output int                                 awaited_count,
  output int                                 result_count
);
  import thr_pkg::*;

  cfg_t               settings;
  logic               tray_lowered;
  logic [STAMP_W-1:0] tray_stamp;
  logic [STAMP_W-1:0] indicator_stamp;
  logic [STAMP_W-1:0] coolant_stamp;
  logic [STAMP_W-1:0] mixing_stamp;
  logic [1:0]         indicator_mode;
  logic               coolant_run;
  logic               mixing_run;
  result_t            expected_results[$];
  result_t            want;
  result_t            got;
  sample_t            smp;
  int                 errors = 0;
  int                 checked = 0;

  initial begin
    mismatch_count = 0;
    awaited_count = 0;
    result_count = 0;
  end

  function automatic logic lockout_expired(input logic [STAMP_W-1:0] now_ms,
                                           input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] elapsed;
    elapsed = now_ms - stamp;
    return elapsed > {{(STAMP_W-LOCK_W){1'b0}}, settings.lockout_ms};
  endfunction

  // Each actuator stamps its time as soon as it acts, so a second check on the
  // same actuator within one request sees no elapsed time and cannot fire.
  function automatic result_t regulate(input sample_t s);
    result_t res;
    int plate;
    int left;
    int right;
    int total;
    int plate_sp;
    int twice_sp;
    int band;
    int cool_band;
    int offset;
    int spread;
    plate = int'($signed(s.plate_temp));
    left = int'($signed(s.left_temp));
    right = int'($signed(s.right_temp));
    total = left + right;
    plate_sp = int'($signed(settings.plate_setpoint));
    twice_sp = 2 * int'($signed(settings.container_setpoint));
    band = int'(settings.plate_hysteresis);
    cool_band = 2 * int'(settings.container_hysteresis);
    offset = total - twice_sp;
    if (offset < 0) offset = -offset;
    spread = left - right;
    if (spread < 0) spread = -spread;
    res = '0;
    res.tray_move = MOVE_NONE;

    if (plate > plate_sp + band && !tray_lowered && lockout_expired(s.now_ms, tray_stamp)) begin
      tray_lowered = 1'b1;
      tray_stamp = s.now_ms;
      res.tray_move = MOVE_LOWER;
    end
    if (plate <= plate_sp - band && tray_lowered && lockout_expired(s.now_ms, tray_stamp)) begin
      tray_lowered = 1'b0;
      tray_stamp = s.now_ms;
      res.tray_move = MOVE_LIFT;
    end

    if (total >= twice_sp + 32 && lockout_expired(s.now_ms, indicator_stamp)) begin
      indicator_mode = IND_OVER;
      indicator_stamp = s.now_ms;
    end
    if (offset < 32 && lockout_expired(s.now_ms, indicator_stamp)) begin
      indicator_mode = IND_NOMINAL;
      indicator_stamp = s.now_ms;
    end
    if (total <= twice_sp - 32 && lockout_expired(s.now_ms, indicator_stamp)) begin
      indicator_mode = IND_UNDER;
      indicator_stamp = s.now_ms;
    end

    if (total > twice_sp + cool_band && lockout_expired(s.now_ms, coolant_stamp)) begin
      coolant_run = 1'b1;
      coolant_stamp = s.now_ms;
    end
    if (total <= twice_sp - cool_band && lockout_expired(s.now_ms, coolant_stamp)) begin
      coolant_run = 1'b0;
      coolant_stamp = s.now_ms;
    end

    if (spread > int'(settings.mix_threshold) && lockout_expired(s.now_ms, mixing_stamp)) begin
      mixing_run = 1'b1;
      mixing_stamp = s.now_ms;
    end
    if (spread <= int'(settings.mix_threshold) && lockout_expired(s.now_ms, mixing_stamp)) begin
      mixing_run = 1'b0;
      mixing_stamp = s.now_ms;
    end

    res.tray_is_down = tray_lowered;
    res.indicator = indicator_mode;
    res.coolant_on = coolant_run;
    res.mixing_on = mixing_run;
    res.container_average = TEMP_W'(total >>> 1);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.plate_setpoint = PLATE_SETPOINT_RST;
      settings.plate_hysteresis = PLATE_HYSTERESIS_RST;
      settings.container_setpoint = CONTAINER_SETPOINT_RST;
      settings.container_hysteresis = CONTAINER_HYSTERESIS_RST;
      settings.mix_threshold = MIX_THRESHOLD_RST;
      settings.lockout_ms = LOCKOUT_MS_RST;
      tray_lowered = 1'b0;
      tray_stamp = '0;
      indicator_stamp = '0;
      coolant_stamp = '0;
      mixing_stamp = '0;
      indicator_mode = IND_UNSET;
      coolant_run = 1'b0;
      mixing_run = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.tray_move = out_tray_move;
        got.tray_is_down = out_tray_is_down;
        got.indicator = out_indicator;
        got.coolant_on = out_coolant_on;
        got.mixing_on = out_mixing_on;
        got.container_average = out_container_average;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] Result accepted with no request pending: move %0d avg %0d",
                     $time, got.tray_move, got.container_average);
        end else begin
          want = expected_results.pop_front();
          if (got.tray_move !== want.tray_move || got.tray_is_down !== want.tray_is_down ||
              got.indicator !== want.indicator || got.coolant_on !== want.coolant_on ||
              got.mixing_on !== want.mixing_on ||
              got.container_average !== want.container_average) begin
            errors++;
            if (errors <= 10)
              $display({"[%0t] Result %0d mismatch: expected move %0d down %0b ind %0d ",
                        "cool %0b mix %0b avg %0d, got move %0d down %0b ind %0d ",
                        "cool %0b mix %0b avg %0d"},
                       $time, checked, want.tray_move, want.tray_is_down, want.indicator,
                       want.coolant_on, want.mixing_on, want.container_average,
                       got.tray_move, got.tray_is_down, got.indicator,
                       got.coolant_on, got.mixing_on, got.container_average);
          end
        end
        checked++;
      end
      if (in_valid && !in_stall) begin
        smp.now_ms = in_now_ms;
        smp.plate_temp = in_plate_temp;
        smp.left_temp = in_left_temp;
        smp.right_temp = in_right_temp;
        expected_results.push_back(regulate(smp));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PLATE_SETPOINT:       settings.plate_setpoint = cfg_wdata[TEMP_W-1:0];
          REG_PLATE_HYSTERESIS:     settings.plate_hysteresis = cfg_wdata[HYST_W-1:0];
          REG_CONTAINER_SETPOINT:   settings.container_setpoint = cfg_wdata[TEMP_W-1:0];
          REG_CONTAINER_HYSTERESIS: settings.container_hysteresis = cfg_wdata[HYST_W-1:0];
          REG_MIX_THRESHOLD:        settings.mix_threshold = cfg_wdata[THR_W-1:0];
          REG_LOCKOUT_MS:           settings.lockout_ms = cfg_wdata[LOCK_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    awaited_count <= expected_results.size();
    result_count <= checked;
  end

endmodule

@@ tb/sv/tb_thermal_hysteresis_regulator.sv @@
`timescale 1ns / 1ps

module tb_thermal_hysteresis_regulator;
  import thr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_GUARD = 5;
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [STAMP_W-1:0]       in_now_ms = '0;
  logic signed [TEMP_W-1:0] in_plate_temp = '0;
  logic signed [TEMP_W-1:0] in_left_temp = '0;
  logic signed [TEMP_W-1:0] in_right_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_tray_move;
  logic                     out_tray_is_down;
  logic [1:0]               out_indicator;
  logic                     out_coolant_on;
  logic                     out_mixing_on;
  logic signed [TEMP_W-1:0] out_container_average;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  int mismatch_count;
  int awaited_count;
  int result_count;

  int send_idle_pct = 10;
  int recv_stall_pct = 47;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int settings_applied = 0;
  logic [STAMP_W-1:0] clock_ms = '0;
  cfg_t active;
  cfg_t extreme;

  thermal_hysteresis_regulator dut (.*);
  thermal_hysteresis_regulator_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles with no request or result accepted", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [STAMP_W-1:0] now_ms, input logic [TEMP_W-1:0] plate,
                             input logic [TEMP_W-1:0] left, input logic [TEMP_W-1:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= now_ms;
    in_plate_temp <= plate;
    in_left_temp <= left;
    in_right_temp <= right;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Unused upper data bits are filled with noise, and the spare indexes are
  // written too; the block must ignore both.
  task automatic apply_settings(input cfg_t c);
    drain();
    write_reg(REG_PLATE_SETPOINT, {4'($urandom), c.plate_setpoint});
    write_reg(REG_PLATE_HYSTERESIS, {7'($urandom), c.plate_hysteresis});
    write_reg(REG_CONTAINER_SETPOINT, {4'($urandom), c.container_setpoint});
    write_reg(REG_CONTAINER_HYSTERESIS, {7'($urandom), c.container_hysteresis});
    write_reg(REG_MIX_THRESHOLD, {4'($urandom), c.mix_threshold});
    write_reg(REG_LOCKOUT_MS, c.lockout_ms);
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    active = c;
    settings_applied++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.plate_setpoint = TEMP_W'($urandom_range(2880) - 880);
    c.plate_hysteresis = HYST_W'($urandom_range(320));
    c.container_setpoint = TEMP_W'($urandom_range(2880) - 880);
    c.container_hysteresis = HYST_W'($urandom_range(320));
    c.mix_threshold = THR_W'($urandom_range(2880));
    c.lockout_ms = ($urandom_range(3) == 0) ? LOCK_W'($urandom) : LOCK_W'($urandom_range(200));
    return c;
  endfunction

  function automatic logic [TEMP_W-1:0] temp_near(input int center, input int spread);
    if ($urandom_range(9) < 2) return TEMP_W'($urandom);
    return TEMP_W'(center + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [STAMP_W-1:0] time_step();
    int unsigned pick;
    int unsigned lock;
    lock = active.lockout_ms;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 15) return $urandom;
    if (pick < 25) return lock + $urandom_range(1);
    return $urandom_range(lock + lock / 2 + 2);
  endfunction

  // Container readings are built around the setpoint with a left/right split
  // near the mixing threshold, so that every band edge is crossed often.
  task automatic send_random_sample();
    int reach;
    int base;
    int half;
    logic [TEMP_W-1:0] left;
    logic [TEMP_W-1:0] right;
    reach = int'(active.container_hysteresis) + 48;
    base = int'($signed(active.container_setpoint)) + int'($urandom_range(2 * reach)) - reach;
    half = int'($urandom_range(active.mix_threshold / 2 + 8));
    if ($urandom_range(1)) half = -half;
    left = ($urandom_range(9) < 2) ? TEMP_W'($urandom) : TEMP_W'(base + half + $urandom_range(1));
    right = ($urandom_range(9) < 2) ? TEMP_W'($urandom) : TEMP_W'(base - half);
    clock_ms = clock_ms + time_step();
    send_sample(clock_ms,
                temp_near(int'($signed(active.plate_setpoint)),
                          int'(active.plate_hysteresis) + 24),
                left, right);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_sample();
  endtask

  initial begin
    active = '{PLATE_SETPOINT_RST, PLATE_HYSTERESIS_RST, CONTAINER_SETPOINT_RST,
               CONTAINER_HYSTERESIS_RST, MIX_THRESHOLD_RST, LOCKOUT_MS_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: lockout boundary, field extremes and a timestamp wrap.
    send_sample(32'd0, 12'sd2047, 12'sd2047, 12'sd2047);
    send_sample(32'd5000, 12'sd2047, 12'sd2047, 12'sd2047);
    send_sample(32'd5001, 12'sd2047, 12'sd2047, -12'sd2048);
    send_sample(32'd5002, -12'sd2048, -12'sd2048, -12'sd2048);
    send_sample(32'hFFFF_FFF0, -12'sd2048, 12'sd96, 12'sd96);
    send_sample(32'h0000_1377, 12'sd2047, 12'sd2047, 12'sd2047);
    send_sample(32'h0000_1379, 12'sd2047, 12'sd2047, 12'sd2047);

    // Zero lockout: hysteresis and indicator band edges, repeated timestamps.
    extreme = active;
    extreme.lockout_ms = '0;
    apply_settings(extreme);
    send_sample(32'd100, 12'sd33, 12'sd111, 12'sd112);
    send_sample(32'd100, 12'sd32, 12'sd112, 12'sd112);
    send_sample(32'd101, 12'sd32, 12'sd112, 12'sd112);
    send_sample(32'd102, 12'sd64, 12'sd80, 12'sd80);
    send_sample(32'd103, 12'sd65, 12'sd104, 12'sd87);
    send_sample(32'd104, 12'sd65, 12'sd104, 12'sd88);
    send_sample(32'd105, 12'sd64, 12'sd97, 12'sd96);
    send_sample(32'd106, -12'sd2048, -12'sd2048, 12'sd2047);
    clock_ms = 32'd106;

    apply_settings(random_settings());
    run_random(350);

    send_idle_pct = 47;
    recv_stall_pct = 10;
    extreme = '{-12'sd880, 9'd320, 12'sd2000, 9'd320, 12'd2880, 16'hFFFF};
    apply_settings(extreme);
    run_random(300);
    extreme = '{12'sd2000, 9'd0, -12'sd880, 9'd0, 12'd0, 16'd0};
    apply_settings(extreme);
    run_random(300);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_settings(random_settings());
    run_random(100);
    drain();
    run_random(50);
    // The result side holds off while requests keep coming, so the block fills.
    hold_requests++;
    run_random(150);
    apply_settings(random_settings());
    run_random(300);

    drain();
    repeat (DRAIN_GUARD) @(posedge clk);
    $display("Ran %0d requests with %0d results checked over %0d register settings.",
             requests_sent, result_count, settings_applied);
    $display("Covered lockout extremes, timestamp wrap, band edges and a long result hold.");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
